// File: src/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants for the scalar Kalman smoother: formats, register map,
// reset values and sequencer state codes.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 24;
    localparam int GAIN_W     = FRAC_W + 1;
    localparam int CNT_W      = $clog2(GAIN_W);
    localparam int ADDR_W     = 3;

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd33554;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd335544;

    localparam logic REG_PROCESS_NOISE = 1'b0;
    localparam logic REG_MEASURE_NOISE = 1'b1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

endpackage

// File: src/scalar_kalman_smoother_unit.sv
// ----------------------------------------------------------------------------
// scalar_kalman_smoother_unit
// One-dimensional Kalman filter, constant-state model. Restoring divider
// for the gain and two shift-add multipliers, one gain bit per cycle.
//
//   channel   dir  signals                              transfer when
//   in        in   in_valid, in_ready, sample           in_valid & in_ready
//   out       out  out_valid, out_ready, estimate       out_valid & out_ready
//   cfg       in   psel, penable, pwrite, paddr, pwdata psel & penable & pwrite
//
// Each item runs through accept, 25 divider steps, 25 multiplier steps and
// one update step; a new sample is accepted only in idle, after that update.
// Reset clears estimate and covariance and loads the noise defaults.
// A result waits in the output register; the update cycle of the next item
// stalls until that result is taken.
// ----------------------------------------------------------------------------
module scalar_kalman_smoother_unit
    import skf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] estimate
);

    logic [DATA_W-1:0]        q_reg;
    logic [DATA_W-1:0]        r_reg;
    logic [1:0]               state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [DATA_W-1:0] est_reg;
    logic [DATA_W-1:0]        p_reg;
    logic                     out_valid_reg;

    logic [DATA_W-1:0]        pred_reg;
    logic [DATA_W:0]          den_reg;
    logic                     den_zero_reg;
    logic [DATA_W+1:0]        rem_reg;
    logic [GAIN_W-1:0]        quo_reg;
    logic signed [DATA_W:0]   innov_reg;

    logic [GAIN_W-1:0]        g1_reg;
    logic [GAIN_W-1:0]        g2_reg;
    logic signed [DATA_W+2:0] hi1_reg;
    logic [GAIN_W-1:0]        lo1_reg;
    logic [DATA_W:0]          hi2_reg;
    logic [GAIN_W-1:0]        lo2_reg;

    // covariance prediction and denominator
    logic [DATA_W:0]          pq_sum;
    logic [DATA_W-1:0]        pred_c;
    assign pq_sum = {1'b0, p_reg} + {1'b0, q_reg};
    assign pred_c = pq_sum[DATA_W] ? {DATA_W{1'b1}} : pq_sum[DATA_W-1:0];

    // divider step
    logic [DATA_W+2:0]        diff;
    logic                     qbit;
    logic [DATA_W+1:0]        rem_sel;
    logic [GAIN_W-1:0]        quo_next;
    logic [GAIN_W-1:0]        gain_fin;
    assign diff     = {1'b0, rem_reg} - {2'b00, den_reg};
    assign qbit     = ~diff[DATA_W+2];
    assign rem_sel  = qbit ? diff[DATA_W+1:0] : rem_reg;
    assign quo_next = {quo_reg[GAIN_W-2:0], qbit};
    assign gain_fin = den_zero_reg ? '0 : quo_next;

    // multiplier steps
    logic signed [DATA_W+3:0] sum1;
    logic [DATA_W+1:0]        sum2;
    assign sum1 = {hi1_reg[DATA_W+2], hi1_reg}
                + (g1_reg[0] ? {{3{innov_reg[DATA_W]}}, innov_reg} : '0);
    assign sum2 = {1'b0, hi2_reg} + (g2_reg[0] ? {2'b00, pred_reg} : '0);

    // final update
    logic signed [DATA_W+3:0] delta;
    logic signed [DATA_W+4:0] est_sum;
    logic signed [DATA_W-1:0] est_sat;
    assign delta   = {hi1_reg, lo1_reg[GAIN_W-1]}
                   + {{(DATA_W+3){1'b0}}, lo1_reg[GAIN_W-2]};
    assign est_sum = {{5{est_reg[DATA_W-1]}}, est_reg} + {delta[DATA_W+3], delta};

    always_comb
    begin
        if (!est_sum[DATA_W+4] && (est_sum[DATA_W+3:DATA_W-1] != '0))
            est_sat = {1'b0, {(DATA_W-1){1'b1}}};
        else if (est_sum[DATA_W+4] && (est_sum[DATA_W+3:DATA_W-1] != '1))
            est_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            est_sat = est_sum[DATA_W-1:0];
    end

    logic cfg_wr;
    logic fin_go;
    assign cfg_wr  = psel & penable & pwrite;
    assign fin_go  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_MEASURE_NOISE) ? r_reg : q_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign estimate  = est_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg         <= PROCESS_NOISE_RST;
            r_reg         <= MEASURE_NOISE_RST;
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            est_reg       <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == REG_PROCESS_NOISE)
                    q_reg <= pwdata;
                else
                    r_reg <= pwdata;
            end

            if (out_valid_reg && out_ready && !fin_go)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == CNT_W'(GAIN_W - 1))
                    begin
                        state_reg <= ST_MUL;
                        cnt_reg   <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_MUL:
                begin
                    if (cnt_reg == CNT_W'(GAIN_W - 1))
                        state_reg <= ST_FIN;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_FIN:
                begin
                    if (fin_go)
                    begin
                        est_reg       <= est_sat;
                        p_reg         <= {hi2_reg[DATA_W-2:0], lo2_reg[GAIN_W-1]};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pred_reg     <= pred_c;
                    den_reg      <= {1'b0, pred_c} + {1'b0, r_reg};
                    den_zero_reg <= (pred_c == '0) && (r_reg == '0);
                    rem_reg      <= {2'b00, pred_c};
                    quo_reg      <= '0;
                    innov_reg    <= {sample[DATA_W-1], sample}
                                  - {est_reg[DATA_W-1], est_reg};
                end
            end
            ST_DIV:
            begin
                quo_reg <= quo_next;
                rem_reg <= {rem_sel[DATA_W:0], 1'b0};
                if (cnt_reg == CNT_W'(GAIN_W - 1))
                begin
                    g1_reg  <= gain_fin;
                    g2_reg  <= GAIN_W'(1 << FRAC_W) - gain_fin;
                    hi1_reg <= '0;
                    hi2_reg <= '0;
                    lo1_reg <= '0;
                    lo2_reg <= '0;
                end
            end
            ST_MUL:
            begin
                g1_reg  <= g1_reg >> 1;
                g2_reg  <= g2_reg >> 1;
                hi1_reg <= sum1[DATA_W+3:1];
                lo1_reg <= {sum1[0], lo1_reg[GAIN_W-1:1]};
                hi2_reg <= sum2[DATA_W+1:1];
                lo2_reg <= {sum2[0], lo2_reg[GAIN_W-1:1]};
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: tb/sv/kalman_estimate_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kalman_estimate_checker
// Watches the register port and both sample/estimate channels of the scalar
// Kalman smoother. It keeps its own copy of the noise settings, estimate and
// covariance, predicts each new estimate when a sample transfer happens and
// compares every estimate transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module kalman_estimate_checker
    import skf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] estimate,
    output int                       mismatch_count,
    output int                       pending
);

    localparam longint UNITY   = longint'(1) << FRAC_W;
    localparam longint COV_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam longint EST_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint EST_MIN = -64'sh0000_0000_8000_0000;

    logic [DATA_W-1:0]        q_noise;
    logic [DATA_W-1:0]        r_noise;
    logic signed [DATA_W-1:0] est_q16;
    logic [DATA_W-1:0]        cov_q24;
    logic signed [DATA_W-1:0] expected_estimates[$];
    logic signed [DATA_W-1:0] want;

    // one filter step: advances est_q16 / cov_q24, returns the new estimate
    function automatic logic signed [DATA_W-1:0] kalman_update(
        input logic signed [DATA_W-1:0] meas);
        longint pred;
        longint den;
        longint gain;
        longint innov;
        longint delta;
        longint next_est;
        pred = longint'(cov_q24) + longint'(q_noise);
        if (pred > COV_MAX)
        begin
            pred = COV_MAX;
        end
        den = pred + longint'(r_noise);
        gain = (den == 0) ? 0 : (pred << FRAC_W) / den;
        if (gain > UNITY)
        begin
            gain = UNITY;
        end
        innov = longint'(meas) - longint'(est_q16);
        delta = (gain * innov + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
        next_est = longint'(est_q16) + delta;
        if (next_est > EST_MAX)
        begin
            next_est = EST_MAX;
        end
        if (next_est < EST_MIN)
        begin
            next_est = EST_MIN;
        end
        est_q16 = DATA_W'(next_est);
        cov_q24 = DATA_W'(((UNITY - gain) * pred) >>> FRAC_W);
        return est_q16;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] exp_val,
                                   input logic [DATA_W-1:0] got_val);
        $display("%0t ns  estimate check: %s (expected %h, got %h)",
                 $time, what, exp_val, got_val);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_noise = PROCESS_NOISE_RST;
            r_noise = MEASURE_NOISE_RST;
            est_q16 = '0;
            cov_q24 = '0;
            expected_estimates.delete();
            mismatch_count = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if ((paddr >> 2) == ADDR_W'(REG_PROCESS_NOISE))
                begin
                    q_noise = pwdata;
                end
                else if ((paddr >> 2) == ADDR_W'(REG_MEASURE_NOISE))
                begin
                    r_noise = pwdata;
                end
            end
            if (in_valid && in_ready)
            begin
                expected_estimates.push_back(kalman_update(sample));
            end
            if (out_valid && out_ready)
            begin
                if (expected_estimates.size() == 0)
                begin
                    report_mismatch("estimate transfer with no sample pending", '0, estimate);
                end
                else
                begin
                    want = expected_estimates.pop_front();
                    if (estimate !== want)
                    begin
                        report_mismatch("estimate field", want, estimate);
                    end
                end
            end
            pending = expected_estimates.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Top of the scalar Kalman smoother bench. Drives samples and noise settings:
// a directed pass over field extremes, zero noise, zero denominator and
// covariance saturation, then random phases with random noise settings and a
// mix of full-range, small, extreme and slowly drifting samples. Both sides
// idle at random; the estimate side also holds off for long stretches.
// ----------------------------------------------------------------------------
module testbench;
    import skf_pkg::*;

    localparam int     ITEM_CYCLES   = 52;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     PHASE_ITEMS   = 250;
    localparam int     RANDOM_PHASES = 6;
    localparam int     DRAIN_LIMIT   = 5000;
    localparam longint TIMEOUT_NS    = 10_000_000;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [DATA_W-1:0] sample;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] estimate;

    int                       mismatch_count;
    int                       pending;
    int                       sent_count;
    logic                     tx_gappy;
    logic signed [DATA_W-1:0] track_sample;

    scalar_kalman_smoother_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .estimate  (estimate)
    );

    kalman_estimate_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .estimate       (estimate),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // estimate side: random stalls per transfer, long hold-offs now and then
    initial
    begin
        int gap;
        int taken;
        logic rx_gappy;
        out_ready = 1'b0;
        rx_gappy = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
            begin
                rx_gappy = $urandom_range(0, 1);
            end
            if (taken == 300 || taken == 1100)
            begin
                gap = HOLD_CYCLES;
            end
            else
            begin
                gap = rx_gappy ? $urandom_range(0, 13) : 0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            taken++;
        end
    end

    task automatic send_sample(input logic signed [DATA_W-1:0] value);
        int gap;
        if (sent_count % 64 == 0)
        begin
            tx_gappy = $urandom_range(0, 1);
        end
        gap = tx_gappy ? $urandom_range(0, 13) : 0;
        sent_count++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_results();
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        @(posedge clk);
    endtask

    // setup + access; psel stays up so back-to-back writes chain cleanly
    task automatic write_register(input logic idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apply_noise(input logic [DATA_W-1:0] q_val, input logic [DATA_W-1:0] r_val);
        in_valid <= 1'b0;
        wait_results();
        write_register(REG_PROCESS_NOISE, q_val);
        write_register(REG_MEASURE_NOISE, r_val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3: return $urandom_range(0, 32'h0010_0000);
            4: return $urandom_range(32'h0010_0000, 32'h0400_0000);
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    // a drifting measurement track in four cases of ten; the rest full-range noise, small values and extremes
    function automatic logic signed [DATA_W-1:0] random_sample();
        logic signed [DATA_W-1:0] next_val;
        case ($urandom_range(0, 9))
            0, 1, 2: next_val = $urandom;
            3, 4: next_val = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            5: next_val = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: next_val = track_sample + int'($urandom_range(0, 32'h0002_0000))
                                - 32'sh0001_0000;
        endcase
        track_sample = next_val;
        return next_val;
    endfunction

    initial
    begin
        int waited;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        sample     = '0;
        sent_count = 0;
        tx_gappy   = 1'b0;
        track_sample = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset noise settings, field extremes
        send_sample(32'sh0000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(32'sh0001_0000);
        send_sample(32'shFFFF_0000);

        // no noise: gain of one, then zero denominator
        apply_noise('0, '0);
        send_sample(32'sh1234_5678);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);

        // covariance sum saturates
        apply_noise('1, '1);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh0000_0000);

        apply_noise('1, '0);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);

        // zero gain
        apply_noise('0, '1);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);

        apply_noise(32'd1, 32'd1);
        send_sample(32'sd1);
        send_sample(-32'sd1);

        repeat (RANDOM_PHASES)
        begin
            apply_noise(pick_noise(), pick_noise());
            repeat (PHASE_ITEMS)
            begin
                send_sample(random_sample());
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (2 * ITEM_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
